// File: sv/mqlt_pkg.sv
// shared constants and codes of the multi queue linked table
package mqlt_pkg;

  // fixed payload widths
  localparam int unsigned OP_W     = 1;
  localparam int unsigned PID_W    = 6;
  localparam int unsigned QNUM_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // default table geometry
  localparam int unsigned PROC_SLOTS_DEF  = 64;
  localparam int unsigned QUEUE_COUNT_DEF = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 1'b0;
  localparam logic [OP_W-1:0] OP_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// File: sv/mqlt_req_if.sv
// request channel: operation, process id and queue number
interface mqlt_req_if;
  logic                           valid;
  logic                           ready;
  logic [mqlt_pkg::OP_W-1:0]      op;
  logic [mqlt_pkg::PID_W-1:0]     proc_id;
  logic [mqlt_pkg::QNUM_W-1:0]    queue_num;

  modport source (output valid, output op, output proc_id, output queue_num, input ready);
  modport sink   (input valid, input op, input proc_id, input queue_num, output ready);
endinterface

// File: sv/mqlt_rsp_if.sv
// response channel: status and process id
interface mqlt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mqlt_pkg::STATUS_W-1:0]  status;
  logic [mqlt_pkg::PID_W-1:0]     result_id;

  modport source (output valid, output status, output result_id, input ready);
  modport sink   (input valid, input status, input result_id, output ready);
endinterface

// File: sv/multi_queue_linked_table_unit.sv
// Multi queue linked table: QUEUE_COUNT FIFO queues of process ids kept as
// doubly linked lists in a shared next/prev link table.
// Channels: req_i (op, proc_id, queue_num) and rsp_o (status, result_id),
// both valid/ready; one response transaction per request transaction.
// The link table lives in two single-port-write synchronous memories
// (next and prev) of PROC_SLOTS + 2*QUEUE_COUNT entries, with registered read data.
// Each request runs through a small sequencer that reads a link, then
// writes the dependent links back one step per cycle:
//   enqueue: S_ENQ_B, S_ENQ_C, then S_DONE loads the response
//   dequeue: S_DEQ_B, S_DEQ_C, S_DEQ_D, then S_DONE (S_DEQ_B to S_DONE when empty)
//   bad queue number, or bad pid on an enqueue: straight to S_DONE
// One request is in flight at a time; the next is taken the cycle after the
// response of the current one is loaded into the output register, so a new
// request may be accepted while that response still waits to be taken.
// After reset a clearing pass writes every table entry, one per cycle; no
// request is accepted during it. When the receiver stalls, the output
// register holds the response and the sequencer waits in its final state.
module multi_queue_linked_table_unit #(
  parameter int unsigned PROC_SLOTS  = mqlt_pkg::PROC_SLOTS_DEF,
  parameter int unsigned QUEUE_COUNT = mqlt_pkg::QUEUE_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mqlt_req_if.sink        req_i,
  mqlt_rsp_if.source      rsp_o
);

  localparam int unsigned TABLE_SIZE = PROC_SLOTS + 2 * QUEUE_COUNT;
  // link width leaves room for an all-ones empty mark outside the table
  localparam int unsigned LW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [LW-1:0] LINK_NONE = {LW{1'b1}};
  localparam logic [LW-1:0] TABLE_END = LW'(TABLE_SIZE);
  localparam logic [LW-1:0] PROC_END  = LW'(PROC_SLOTS);
  localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_SIZE - 1);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ENQ_B = 8'b0000_0100,
    S_ENQ_C = 8'b0000_1000,
    S_DEQ_B = 8'b0001_0000,
    S_DEQ_C = 8'b0010_0000,
    S_DEQ_D = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] init_cnt_q, init_cnt_d;

  // working registers of the current transaction
  logic [mqlt_pkg::PID_W-1:0]    pid_q, pid_d;
  logic [LW-1:0]                 node_q, node_d;   // tail on enqueue, first on dequeue
  logic [mqlt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [mqlt_pkg::PID_W-1:0]    res_id_q, res_id_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [mqlt_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [mqlt_pkg::PID_W-1:0]    out_id_q, out_id_d;

  // memory ports
  logic [LW-1:0] nxt_mem [TABLE_SIZE];
  logic [LW-1:0] prv_mem [TABLE_SIZE];
  logic          nxt_we, prv_we;
  logic [LW-1:0] nxt_waddr, prv_waddr, nxt_wdata, prv_wdata;
  logic [AW-1:0] nxt_raddr, prv_raddr;
  logic [LW-1:0] nxt_rdata_q, prv_rdata_q;

  // request decode
  logic          req_fire, rsp_fire, out_free;
  logic          bad_queue, bad_pid;
  logic [LW-1:0] head_idx, tail_idx;
  logic [LW-1:0] init_idx, init_ofs;
  logic          init_head, init_tail;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign bad_queue = 7'(req_i.queue_num) >= 7'(QUEUE_COUNT);
  assign bad_pid   = 11'(req_i.proc_id) >= 11'(PROC_SLOTS);
  assign head_idx  = LW'(PROC_SLOTS + 2 * int'(req_i.queue_num));
  assign tail_idx  = LW'(PROC_SLOTS + 2 * int'(req_i.queue_num) + 1);

  // reset pattern of the entry being cleared
  assign init_idx  = LW'(init_cnt_q);
  assign init_ofs  = init_idx - PROC_END;
  assign init_head = (init_idx >= PROC_END) && !init_ofs[0];
  assign init_tail = (init_idx >= PROC_END) && init_ofs[0];

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.result_id = out_id_q;

  // sequencer and memory port control
  always_comb begin
    state_d      = state_q;
    init_cnt_d   = init_cnt_q;
    pid_d        = pid_q;
    node_d       = node_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    nxt_we       = 1'b0;
    prv_we       = 1'b0;
    nxt_waddr    = '0;
    prv_waddr    = '0;
    nxt_wdata    = LINK_NONE;
    prv_wdata    = LINK_NONE;
    nxt_raddr    = '0;
    prv_raddr    = '0;

    unique case (state_q)
      S_INIT: begin
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        nxt_waddr = init_idx;
        prv_waddr = init_idx;
        nxt_wdata = init_head ? init_idx + LW'(1) : LINK_NONE;
        prv_wdata = init_tail ? init_idx - LW'(1) : LINK_NONE;
        init_cnt_d = init_cnt_q + AW'(1);
        if (init_cnt_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          pid_d    = req_i.proc_id;
          res_id_d = '0;
          if (bad_queue || (req_i.op == mqlt_pkg::OP_ENQ && bad_pid)) begin
            res_status_d = mqlt_pkg::STATUS_BAD;
            state_d      = S_DONE;
          end else if (req_i.op == mqlt_pkg::OP_ENQ) begin
            // read the node before the tail, point the new id at the tail
            node_d    = tail_idx;
            prv_raddr = tail_idx[AW-1:0];
            nxt_we    = 1'b1;
            nxt_waddr = LW'(req_i.proc_id);
            nxt_wdata = tail_idx;
            state_d   = S_ENQ_B;
          end else begin
            nxt_raddr = head_idx[AW-1:0];
            state_d   = S_DEQ_B;
          end
        end
      end
      S_ENQ_B: begin
        // prev of new id is the old last node, which now points at the id
        prv_we    = 1'b1;
        prv_waddr = LW'(pid_q);
        prv_wdata = prv_rdata_q;
        nxt_we    = 1'b1;
        nxt_waddr = prv_rdata_q;
        nxt_wdata = LW'(pid_q);
        state_d   = S_ENQ_C;
      end
      S_ENQ_C: begin
        prv_we       = 1'b1;
        prv_waddr    = node_q;
        prv_wdata    = LW'(pid_q);
        res_status_d = mqlt_pkg::STATUS_OK;
        res_id_d     = pid_q;
        state_d      = S_DONE;
      end
      S_DEQ_B: begin
        node_d = nxt_rdata_q;
        if (nxt_rdata_q >= PROC_END) begin
          res_status_d = mqlt_pkg::STATUS_EMPTY;
          state_d      = S_DONE;
        end else begin
          nxt_raddr = nxt_rdata_q[AW-1:0];
          prv_raddr = nxt_rdata_q[AW-1:0];
          state_d   = S_DEQ_C;
        end
      end
      S_DEQ_C: begin
        // bridge the neighbors of the removed node
        nxt_we    = 1'b1;
        nxt_waddr = prv_rdata_q;
        nxt_wdata = nxt_rdata_q;
        prv_we    = 1'b1;
        prv_waddr = nxt_rdata_q;
        prv_wdata = prv_rdata_q;
        state_d   = S_DEQ_D;
      end
      S_DEQ_D: begin
        nxt_we       = 1'b1;
        nxt_waddr    = node_q;
        nxt_wdata    = LINK_NONE;
        prv_we       = 1'b1;
        prv_waddr    = node_q;
        prv_wdata    = LINK_NONE;
        res_status_d = mqlt_pkg::STATUS_OK;
        res_id_d     = node_q[mqlt_pkg::PID_W-1:0];
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  // output register, loaded when the sequencer finishes
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    if (rsp_fire) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_id_d     = res_id_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pid_q        <= pid_d;
    node_q       <= node_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
  end

  // next link memory; writes outside the table are dropped
  always_ff @(posedge clk_i) begin
    if (nxt_we && nxt_waddr < TABLE_END) begin
      nxt_mem[nxt_waddr[AW-1:0]] <= nxt_wdata;
    end
    nxt_rdata_q <= nxt_mem[nxt_raddr];
  end

  // prev link memory
  always_ff @(posedge clk_i) begin
    if (prv_we && prv_waddr < TABLE_END) begin
      prv_mem[prv_waddr[AW-1:0]] <= prv_wdata;
    end
    prv_rdata_q <= prv_mem[prv_raddr];
  end

endmodule
